[rtl/iorrb_pkg.sv]
// Package for the in-order release reorder buffer.
// Holds the beat structs, queue command and back-end state types.
// No dependencies.
package iorrb_pkg;

  localparam int SEQ_BITS     = 16;
  localparam int PAYLOAD_BITS = 8;
  localparam int CMDQ_DEPTH   = 2;

  typedef struct packed {
    logic [SEQ_BITS-1:0]     seq_num;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [SEQ_BITS-1:0]     out_seq;
    logic                    last_in_run;
    logic                    rejected;
  } out_item_t;

  typedef enum logic {
    CMD_REJECT,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    in_item_t  item;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] expected_seq;
    logic                drain_done;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

endpackage

[rtl/in_order_release_reorder_buffer_unit.sv]
// In-order release reorder buffer. A rejected beat goes through the command queue
// and is loaded as a result once the back end is idle and the result is free.
// An expected beat starts a run; each released item takes a slot RAM read, then
// a result load, and input stays full until the run's last item is loaded.
// A stored beat is only written to the slot RAM. Reset (synchronous) clears valid
// bits, sets the expected number to 1; the payload RAM is not cleared.
module in_order_release_reorder_buffer_unit import iorrb_pkg::*; #(
  parameter int WINDOW = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int IDX_BITS = $clog2(WINDOW);

  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  cmd_t                    q_wr_cmd;
  cmd_t                    q_rd_cmd;
  logic                    wr_en;
  logic [IDX_BITS-1:0]     wr_addr;
  logic [PAYLOAD_BITS-1:0] wr_data;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]     head;
  back_status_t            status;

  iorrb_front #(.WINDOW(WINDOW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .status  (status),
    .head    (head),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  iorrb_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_cmd  (q_wr_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (q_rd_cmd),
    .q_empty (q_empty)
  );

  iorrb_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(WINDOW)) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  iorrb_back #(.WINDOW(WINDOW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_rd_cmd),
    .q_pop   (q_pop),
    .set_en  (wr_en),
    .set_idx (wr_addr),
    .rd_data (rd_data),
    .head    (head),
    .status  (status),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

`ifndef SYNTH
  a_done_while_locked: assert property (@(posedge clk) disable iff (rst)
    status.drain_done |-> full)
    else $error("run finished while input was not locked");

  a_expected_moves_locked: assert property (@(posedge clk) disable iff (rst)
    (status.expected_seq != $past(status.expected_seq)) |-> $past(full))
    else $error("expected number advanced while input was open");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  a_no_queue_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue underflow");
`endif

endmodule

[rtl/iorrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iorrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/iorrb_cmdq.sv]
// Short command queue between the front and back ends.
// Depends on iorrb_pkg for cmd_t and the queue depth.
module iorrb_cmdq import iorrb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic q_full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_empty
);

  localparam int PTR_BITS = $clog2(CMDQ_DEPTH);

  cmd_t                entries [CMDQ_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign q_full  = (count == (PTR_BITS+1)'(CMDQ_DEPTH));
  assign q_empty = (count == '0);
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_BITS+1)'(wr_en) - (PTR_BITS+1)'(rd_en);
    end
  end

endmodule

[rtl/iorrb_front.sv]
// Front end: accepts input beats, applies the window test, stores in-window
// payloads and queues reject and drain commands. Depends on iorrb_pkg.
module iorrb_front import iorrb_pkg::*; #(
  parameter int WINDOW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  in_item_t                  item,
  input  back_status_t              status,
  input  logic [$clog2(WINDOW)-1:0] head,
  input  logic                      q_full,
  output logic                      q_push,
  output cmd_t                      q_cmd,
  output logic                      wr_en,
  output logic [$clog2(WINDOW)-1:0] wr_addr,
  output logic [PAYLOAD_BITS-1:0]   wr_data
);

  localparam int IDX_BITS = $clog2(WINDOW);
  localparam logic [SEQ_BITS:0] WIN_SEQ = (SEQ_BITS+1)'(WINDOW);
  localparam logic [IDX_BITS:0] WIN_IDX = (IDX_BITS+1)'(WINDOW);

  logic                busy;
  logic                accept;
  logic [SEQ_BITS-1:0] seq_dist;
  logic                in_win;
  logic                is_expected;
  logic [IDX_BITS:0]   idx_sum;

  assign full        = busy || q_full;
  assign accept      = push && !full;
  assign seq_dist    = item.seq_num - status.expected_seq;
  assign in_win      = {1'b0, seq_dist} < WIN_SEQ;
  assign is_expected = (seq_dist == '0);
  assign idx_sum     = {1'b0, head} + {1'b0, seq_dist[IDX_BITS-1:0]};

  always_comb begin
    wr_addr = (idx_sum >= WIN_IDX) ? IDX_BITS'(idx_sum - WIN_IDX) : idx_sum[IDX_BITS-1:0];
  end

  assign wr_en      = accept && in_win;
  assign wr_data    = item.payload;
  assign q_push     = accept && (!in_win || is_expected);
  assign q_cmd.kind = in_win ? CMD_DRAIN : CMD_REJECT;
  assign q_cmd.item = item;

  // hold the input from the expected beat until its run has drained
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && in_win && is_expected) begin
      busy <= 1'b1;
    end else if (status.drain_done) begin
      busy <= 1'b0;
    end
  end

endmodule

[rtl/iorrb_back.sv]
// Back end: executes queued commands, releases runs from the slot RAM in
// order and holds the result register. Depends on iorrb_pkg.
module iorrb_back import iorrb_pkg::*; #(
  parameter int WINDOW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  input  logic                      set_en,
  input  logic [$clog2(WINDOW)-1:0] set_idx,
  input  logic [PAYLOAD_BITS-1:0]   rd_data,
  output logic [$clog2(WINDOW)-1:0] head,
  output back_status_t              status,
  output logic                      empty,
  input  logic                      pop,
  output out_item_t                 result
);

  localparam int IDX_BITS = $clog2(WINDOW);

  back_state_t         state;
  back_state_t         state_next;
  logic [WINDOW-1:0]   slot_valid;
  logic [IDX_BITS-1:0] head_inc;
  logic [SEQ_BITS-1:0] expected_seq;
  logic                out_valid;
  logic                out_free;
  logic                load_reject;
  logic                load_run;
  logic                run_last;

  assign head_inc     = (head == IDX_BITS'(WINDOW - 1)) ? '0 : head + 1'b1;
  assign out_free     = !out_valid || pop;
  assign run_last     = !slot_valid[head_inc];
  assign empty        = !out_valid;

  always_comb begin
    state_next          = state;
    q_pop               = 1'b0;
    load_reject         = 1'b0;
    load_run            = 1'b0;
    status.expected_seq = expected_seq;
    status.drain_done   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == CMD_REJECT) begin
            if (out_free) begin
              q_pop       = 1'b1;
              load_reject = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            state_next = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load_run = 1'b1;
          if (run_last) begin
            status.drain_done = 1'b1;
            state_next        = BK_IDLE;
          end else begin
            state_next = BK_FETCH;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      head         <= IDX_BITS'(1 % WINDOW);
      expected_seq <= SEQ_BITS'(1);
    end else begin
      if (set_en) begin
        slot_valid[set_idx] <= 1'b1;
      end
      if (load_run) begin
        slot_valid[head] <= 1'b0;
        head             <= head_inc;
        expected_seq     <= expected_seq + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_reject || load_run) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_reject) begin
      result.out_payload <= q_cmd.item.payload;
      result.out_seq     <= q_cmd.item.seq_num;
      result.last_in_run <= 1'b0;
      result.rejected    <= 1'b1;
    end else if (load_run) begin
      result.out_payload <= rd_data;
      result.out_seq     <= expected_seq;
      result.last_in_run <= run_last;
      result.rejected    <= 1'b0;
    end
  end

endmodule

[verif/tb_in_order_release_reorder_buffer_unit.sv]
// Testbench for the in-order release reorder buffer: directed, longest-run, backpressure,
// wrap and random beats, with an in-bench ring predictor and a result checker.
// Depends on iorrb_pkg and in_order_release_reorder_buffer_unit.
`timescale 1ns / 1ps

module tb_in_order_release_reorder_buffer_unit;
  import iorrb_pkg::*;

  localparam int WIN         = 32;
  localparam int MAX_GAP     = 17;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  logic [PAYLOAD_BITS-1:0] ring_pay [WIN];
  bit                      ring_vld [WIN];
  logic [SEQ_BITS-1:0]     next_seq = SEQ_BITS'(1);
  int                      ring_head = 1 % WIN;
  out_item_t               outgoing_q [$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;
  int beats_in = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  in_order_release_reorder_buffer_unit #(.WINDOW(WIN)) dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic apply_arrival(input logic [SEQ_BITS-1:0] seq,
                               input logic [PAYLOAD_BITS-1:0] pay);
    logic [SEQ_BITS-1:0] seq_dist;
    out_item_t           r;
    int                  slot;
    int                  n;
    bit                  more;
    seq_dist = seq - next_seq;
    if (seq_dist >= WIN) begin
      r.out_payload = pay;
      r.out_seq     = seq;
      r.last_in_run = 1'b0;
      r.rejected    = 1'b1;
      outgoing_q.push_back(r);
    end else begin
      slot = (ring_head + int'(seq_dist)) % WIN;
      ring_pay[slot] = pay;
      ring_vld[slot] = 1'b1;
      if (seq_dist == 0) begin
        n = 0;
        more = 1'b1;
        while (more) begin
          r.out_payload = ring_pay[ring_head];
          r.out_seq     = next_seq;
          r.rejected    = 1'b0;
          ring_vld[ring_head] = 1'b0;
          next_seq++;
          ring_head = (ring_head + 1) % WIN;
          n++;
          more = (n < WIN) && ring_vld[ring_head];
          r.last_in_run = !more;
          outgoing_q.push_back(r);
        end
      end
    end
  endtask

  task automatic send_beat(input logic [SEQ_BITS-1:0] seq,
                           input logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{seq_num: seq, payload: pay};
    do @(posedge clk); while (full);
    apply_arrival(seq, pay);
    beats_in++;
  endtask

  // Send offsets 0..len-1 from the expected number, descending or shuffled, optionally dropping one or duplicating one.
  task automatic send_group(input int len, input bit shuffled, input bit drop_one,
                            input bit dup);
    int                  offs [$];
    int                  j;
    int                  tmp;
    logic [SEQ_BITS-1:0] base;
    base = next_seq;
    for (int i = len - 1; i >= 0; i--) offs.push_back(i);
    if (shuffled) begin
      for (int i = len - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = offs[i];
        offs[i] = offs[j];
        offs[j] = tmp;
      end
    end
    if (drop_one && len > 1) offs.delete($urandom_range(0, len - 1));
    if (dup)
      offs.insert($urandom_range(0, offs.size()),
                  offs[$urandom_range(0, offs.size() - 1)]);
    foreach (offs[k]) send_beat(base + SEQ_BITS'(offs[k]), PAYLOAD_BITS'($urandom));
  endtask

  task automatic finish_phase();
    push <= 1'b0;
    while (outgoing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic test_directed();
    send_beat(16'd1, 8'h00);
    send_beat(16'hFFFF, 8'hFF);
    send_beat(16'd0, 8'h5A);
    send_beat(16'd1, 8'hA5);
    send_beat(16'd33, 8'h3C);
    send_beat(16'd34, 8'hC3);
    send_beat(16'd4, 8'hAA);
    send_beat(16'd4, 8'h55);
    send_beat(16'd3, 8'h0F);
    send_beat(16'd2, 8'hF0);
    send_beat(16'h8000, 8'h81);
    finish_phase();
  endtask

  task automatic test_longest_run();
    send_group(WIN, 1'b0, 1'b0, 1'b0);
    finish_phase();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 400;
    for (int i = 0; i < 16; i++)
      send_beat(next_seq + SEQ_BITS'($urandom_range(WIN, 1000)), PAYLOAD_BITS'($urandom));
    send_group(WIN, 1'b0, 1'b0, 1'b0);
    send_group(WIN, 1'b1, 1'b0, 1'b0);
    finish_phase();
  endtask

  // Probe the window edges, where the distance wraps around the expected number.
  task automatic test_seq_wrap();
    logic [SEQ_BITS-1:0] base;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    base = next_seq;
    send_beat(base - SEQ_BITS'(1), 8'h11);
    send_beat(base + SEQ_BITS'(WIN - 1), 8'h22);
    send_beat(base + SEQ_BITS'(WIN), 8'h33);
    send_beat(base - SEQ_BITS'(WIN), 8'h44);
    send_group(WIN - 1, 1'b0, 1'b0, 1'b0);
    finish_phase();
  endtask

  task automatic test_random();
    int start;
    int pick;
    start = beats_in;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (beats_in < start + 300) begin
      if ($urandom_range(0, 99) < 6) begin
        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_group(($urandom_range(0, 9) == 0) ? $urandom_range(9, WIN)
                                               : $urandom_range(1, 8),
                   1'b1, $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0);
      else if (pick < 80)
        send_beat(SEQ_BITS'($urandom), PAYLOAD_BITS'($urandom));
      else if (pick < 90)
        send_beat(next_seq - SEQ_BITS'($urandom_range(1, 40)), PAYLOAD_BITS'($urandom));
      else
        send_beat(next_seq + SEQ_BITS'($urandom_range(WIN, 400)), PAYLOAD_BITS'($urandom));
    end
    finish_phase();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_longest_run();
    test_backpressure();
    test_seq_wrap();
    test_random();
    if (mismatches == 0 && outgoing_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : result_drain
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold > 0) begin
        pop <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (outgoing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: pay %h seq %h last %b rej %b", result.out_payload,
                   result.out_seq, result.last_in_run, result.rejected);
      end else begin
        want = outgoing_q.pop_front();
        if (result.out_payload !== want.out_payload || result.out_seq !== want.out_seq ||
            result.last_in_run !== want.last_in_run || result.rejected !== want.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected pay %h seq %h last %b rej %b, ",
                      "got pay %h seq %h last %b rej %b"},
                     want.out_payload, want.out_seq, want.last_in_run, want.rejected,
                     result.out_payload, result.out_seq, result.last_in_run, result.rejected);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
